FILE: hdl/skwm_pkg.sv
// Shared types and fixed-point constants for the soft-knee waveshaper with mix.
// Used by soft_knee_waveshaper_mix; depends on nothing.
`default_nettype none

package skwm_pkg;

	// Internal fixed-point format of the driven sample: Q.24
	localparam int IFRAC = 24;
	// Signed width of the driven sample x (|x| < 2^28 for any drive)
	localparam int XW = 29;
	// Threshold a = 2 * knee_threshold, unsigned Q0.24
	localparam int AW = 24;
	// Width of x - a, span 1 - a, and the divider quotients
	localparam int DW = 25;

	localparam logic signed [XW-1:0] ONE_Q       = 29'sd16777216;
	localparam logic signed [XW-1:0] NEG_LIMIT_Q = -29'sd13421773;
	localparam logic [DW-1:0]        ONE_U       = 25'd16777216;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_DRIVE_GAIN     = 2'd0;
	localparam cfg_idx_t REG_KNEE_THRESHOLD = 2'd1;
	localparam cfg_idx_t REG_MIX_LEVEL      = 2'd2;

	localparam logic [15:0] DRIVE_GAIN_RST     = 16'd4096;
	localparam logic [22:0] KNEE_THRESHOLD_RST = 23'd4194304;
	localparam logic [16:0] MIX_LEVEL_RST      = 17'd0;

	// Which piece of the curve applies to a sample
	typedef logic [1:0] knee_sel_t;
	localparam knee_sel_t KSEL_PASS = 2'd0;  // x at or below a
	localparam knee_sel_t KSEL_TOP  = 2'd1;  // x above one
	localparam knee_sel_t KSEL_KNEE = 2'd2;  // a < x <= 1
	localparam knee_sel_t KSEL_NEG  = 2'd3;  // x below the negative limit

endpackage

`default_nettype wire

FILE: hdl/skwm_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband that travels alongside. Stand-alone, no package dependency.
`default_nettype none

module skwm_div #(
	parameter int NUM_W  = 49,
	parameter int DEN_W  = 25,
	parameter int QUO_W  = 25,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [QUO_W-1:0]       quo,
	output logic [SIDE_W-1:0]      side_out
);

	// Caller keeps num >> QUO_W below den, so the quotient fits QUO_W bits.
	logic              valid_s [1:QUO_W];
	logic [DEN_W-1:0]  rem_s   [1:QUO_W];
	logic [QUO_W-1:0]  low_s   [1:QUO_W];  // dividend bits out at top, quotient in at bottom
	logic [DEN_W-1:0]  den_s   [1:QUO_W];
	logic [SIDE_W-1:0] side_s  [1:QUO_W];

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic              valid_prev;
		logic [DEN_W-1:0]  rem_prev;
		logic [QUO_W-1:0]  low_prev;
		logic [DEN_W-1:0]  den_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              fits;

		if (k == 1) begin : g_first
			assign valid_prev = in_valid;
			assign rem_prev   = DEN_W'(num[NUM_W-1:QUO_W]);
			assign low_prev   = num[QUO_W-1:0];
			assign den_prev   = den;
			assign side_prev  = side_in;
		end else begin : g_next
			assign valid_prev = valid_s[k-1];
			assign rem_prev   = rem_s[k-1];
			assign low_prev   = low_s[k-1];
			assign den_prev   = den_s[k-1];
			assign side_prev  = side_s[k-1];
		end

		assign trial = {rem_prev, low_prev[QUO_W-1]};
		assign diff  = trial - {1'b0, den_prev};
		assign fits  = ~diff[DEN_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k]  <= {low_prev[QUO_W-2:0], fits};
				den_s[k]  <= den_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign quo       = low_s[QUO_W];
	assign side_out  = side_s[QUO_W];

endmodule

`default_nettype wire

FILE: hdl/soft_knee_waveshaper_mix.sv
// Soft-knee waveshaper with dry/wet mix: top level, 58-stage pipeline.
// Depends on skwm_pkg and skwm_div.
//
// Usage:
//   Input channel  : sample_in with in_valid; the block drives in_stall. A sample
//                    transfers at a rising edge with in_valid high and in_stall low.
//   Output channel : sample_out with out_valid; the receiver drives out_stall. A
//                    result transfers at a rising edge with out_valid high and
//                    out_stall low. One result per input sample, in order.
//   Config channel : cfg_index / cfg_data with cfg_valid; cfg_ready is always high.
//                    Index 0 drive_gain, 1 knee_threshold, 2 mix_level; index 3 is
//                    dropped. Write only while the pipeline holds no sample.
//   Throughput     : one sample per clock unless in_stall is high. The two quotients
//                    of the knee term come from two 25-stage dividers, one quotient
//                    bit per stage.
//   Reset          : arst_n clears all stage valid bits and loads the register
//                    defaults (unity drive, a = 0.5, fully wet).
//   Stall          : the pipeline keeps advancing while its last stage is empty,
//                    so bubbles close up behind a waiting result; in_stall rises
//                    only once a result waits at the output and another one is
//                    ready behind it.
`default_nettype none

module soft_knee_waveshaper_mix #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input sample channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire skwm_pkg::cfg_idx_t             cfg_index,
	input  wire skwm_pkg::cfg_data_t            cfg_data
);

	localparam int XW     = skwm_pkg::XW;
	localparam int DW     = skwm_pkg::DW;
	localparam int AW     = skwm_pkg::AW;
	localparam int IFRAC  = skwm_pkg::IFRAC;
	localparam int FRAC   = SAMPLE_BITS - 1;
	localparam int BIG    = (FRAC > IFRAC) ? FRAC : IFRAC;
	// sample (Q.FRAC) times drive (Q4.12) lands in Q.(FRAC+12); shift to Q.24
	localparam int XSHIFT = FRAC - 12;
	localparam int PROD_W = SAMPLE_BITS + 17;
	localparam int NUM_W  = DW + IFRAC;
	localparam int DEN2_W = DW + 1;
	localparam int SH_WET = BIG - IFRAC;
	localparam int SH_DRY = BIG - FRAC;
	localparam int RSHIFT = BIG + 16 - FRAC;
	localparam int P1_W   = 18 + XW;
	localparam int P2_W   = 18 + SAMPLE_BITS;
	localparam int ACC_A  = P1_W + SH_WET;
	localparam int ACC_B  = P2_W + SH_DRY;
	localparam int ACC_W  = ((ACC_A > ACC_B) ? ACC_A : ACC_B) + 1;
	localparam int SIDE1_W = XW + SAMPLE_BITS + 2 + DW;
	localparam int SIDE2_W = XW + SAMPLE_BITS + 2;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		signed'({{(ACC_W - FRAC){1'b0}}, {FRAC{1'b1}}});
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = signed'(ACC_W'(1) << (RSHIFT - 1));

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] drive_gain_q;
	logic [22:0] knee_threshold_q;
	logic [16:0] mix_level_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_gain_q     <= skwm_pkg::DRIVE_GAIN_RST;
			knee_threshold_q <= skwm_pkg::KNEE_THRESHOLD_RST;
			mix_level_q      <= skwm_pkg::MIX_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				skwm_pkg::REG_DRIVE_GAIN:     drive_gain_q     <= cfg_data[15:0];
				skwm_pkg::REG_KNEE_THRESHOLD: knee_threshold_q <= cfg_data[22:0];
				skwm_pkg::REG_MIX_LEVEL:      mix_level_q      <= cfg_data[16:0];
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// Values derived from the registers; the user must keep them static while samples are in flight (not enforced)
	logic [AW-1:0]        a_val;
	logic signed [XW-1:0] a_sx;
	logic [DW-1:0]        span;
	logic [16:0]          mix_eff;
	logic [16:0]          wet;

	assign a_val   = {knee_threshold_q, 1'b0};
	assign a_sx    = signed'(XW'(a_val));
	assign span    = skwm_pkg::ONE_U - DW'(a_val);
	// anything above 65536 counts as fully dry
	assign mix_eff = mix_level_q[16] ? 17'd65536 : mix_level_q;
	assign wet     = 17'd65536 - mix_eff;

	// ------------------------------------------------------------------
	// Flow control: one enable for every stage. Advance whenever the output
	// register can take a result or the last stage holds nothing.
	// ------------------------------------------------------------------
	logic v_s7;
	logic load_out;
	logic en;

	assign load_out = !out_valid || !out_stall;
	assign en       = load_out || !v_s7;
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: drive gain, floor to Q.24
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0]      prod;
	logic                          v_s1;
	logic signed [XW-1:0]          x_s1;
	logic signed [SAMPLE_BITS-1:0] dry_s1;

	assign prod = PROD_W'(sample_in) * PROD_W'(signed'({1'b0, drive_gain_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= prod[XSHIFT +: XW];  // part-select of a signed product floors
			dry_s1 <= sample_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: pick the curve segment, form x - a for the knee
	// ------------------------------------------------------------------
	skwm_pkg::knee_sel_t           sel_next;
	logic signed [XW-1:0]          xa_diff;
	logic                          v_s2;
	logic signed [XW-1:0]          x_s2;
	logic signed [SAMPLE_BITS-1:0] dry_s2;
	skwm_pkg::knee_sel_t           sel_s2;
	logic [DW-1:0]                 d_s2;

	assign xa_diff = x_s1 - a_sx;

	always_comb begin
		// the negative clamp overrides every other segment
		priority if (x_s1 < skwm_pkg::NEG_LIMIT_Q) begin
			sel_next = skwm_pkg::KSEL_NEG;
		end else if (x_s1 <= a_sx) begin
			sel_next = skwm_pkg::KSEL_PASS;
		end else if (x_s1 > skwm_pkg::ONE_Q) begin
			sel_next = skwm_pkg::KSEL_TOP;
		end else begin
			sel_next = skwm_pkg::KSEL_KNEE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_s1;
			dry_s2 <= dry_s1;
			sel_s2 <= sel_next;
			// zero outside the knee keeps the dividers inside their range
			d_s2   <= (sel_next == skwm_pkg::KSEL_KNEE) ? xa_diff[DW-1:0] : '0;
		end
	end

	// ------------------------------------------------------------------
	// Divider 1: r = (x - a) * 2^24 / (1 - a)
	// ------------------------------------------------------------------
	logic                          v_d1;
	logic [DW-1:0]                 r_d1;
	logic [SIDE1_W-1:0]            side1_out;
	logic signed [XW-1:0]          x_d1;
	logic signed [SAMPLE_BITS-1:0] dry_d1;
	skwm_pkg::knee_sel_t           sel_d1;
	logic [DW-1:0]                 d_d1;

	skwm_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (DW),
		.QUO_W  (DW),
		.SIDE_W (SIDE1_W)
	) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      ({d_s2, {IFRAC{1'b0}}}),
		.den      (span),
		.side_in  ({x_s2, dry_s2, sel_s2, d_s2}),
		.out_valid(v_d1),
		.quo      (r_d1),
		.side_out (side1_out)
	);

	assign {x_d1, dry_d1, sel_d1, d_d1} = side1_out;

	// ------------------------------------------------------------------
	// Stage 3: r2 = r * r / 2^24
	// ------------------------------------------------------------------
	logic [2*DW-1:0]               r_sq;
	logic                          v_s3;
	logic [DW-1:0]                 r2_s3;
	logic signed [XW-1:0]          x_s3;
	logic signed [SAMPLE_BITS-1:0] dry_s3;
	skwm_pkg::knee_sel_t           sel_s3;
	logic [DW-1:0]                 d_s3;

	assign r_sq = (2*DW)'(r_d1) * (2*DW)'(r_d1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3  <= r_sq[IFRAC +: DW];
			x_s3   <= x_d1;
			dry_s3 <= dry_d1;
			sel_s3 <= sel_d1;
			d_s3   <= d_d1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: denominator 1 + r2 (reaches 2.0 at the top of the knee)
	// ------------------------------------------------------------------
	logic                          v_s4;
	logic [DEN2_W-1:0]             den_s4;
	logic signed [XW-1:0]          x_s4;
	logic signed [SAMPLE_BITS-1:0] dry_s4;
	skwm_pkg::knee_sel_t           sel_s4;
	logic [DW-1:0]                 d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= DEN2_W'(skwm_pkg::ONE_U) + DEN2_W'(r2_s3);
			x_s4   <= x_s3;
			dry_s4 <= dry_s3;
			sel_s4 <= sel_s3;
			d_s4   <= d_s3;
		end
	end

	// ------------------------------------------------------------------
	// Divider 2: q = (x - a) * 2^24 / (1 + r2)
	// ------------------------------------------------------------------
	logic                          v_d2;
	logic [DW-1:0]                 q_d2;
	logic [SIDE2_W-1:0]            side2_out;
	logic signed [XW-1:0]          x_d2;
	logic signed [SAMPLE_BITS-1:0] dry_d2;
	skwm_pkg::knee_sel_t           sel_d2;

	skwm_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (DEN2_W),
		.QUO_W  (DW),
		.SIDE_W (SIDE2_W)
	) u_div_knee (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      ({d_s4, {IFRAC{1'b0}}}),
		.den      (den_s4),
		.side_in  ({x_s4, dry_s4, sel_s4}),
		.out_valid(v_d2),
		.quo      (q_d2),
		.side_out (side2_out)
	);

	assign {x_d2, dry_d2, sel_d2} = side2_out;

	// ------------------------------------------------------------------
	// Stage 5: shaped value
	// ------------------------------------------------------------------
	logic signed [XW-1:0]          shaped_next;
	logic [DW-1:0]                 top_sum;
	logic                          v_s5;
	logic signed [XW-1:0]          shaped_s5;
	logic signed [SAMPLE_BITS-1:0] dry_s5;

	assign top_sum = DW'(a_val) + skwm_pkg::ONE_U;

	always_comb begin
		unique case (sel_d2)
			skwm_pkg::KSEL_PASS: shaped_next = x_d2;
			skwm_pkg::KSEL_TOP:  shaped_next = signed'(XW'(top_sum >> 1));
			skwm_pkg::KSEL_KNEE: shaped_next = signed'(XW'(a_val) + XW'(q_d2));
			skwm_pkg::KSEL_NEG:  shaped_next = skwm_pkg::NEG_LIMIT_Q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shaped_s5 <= shaped_next;
			dry_s5    <= dry_d2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: wet and dry products
	// ------------------------------------------------------------------
	logic                    v_s6;
	logic signed [P1_W-1:0]  p1_s6;
	logic signed [P2_W-1:0]  p2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s6 <= P1_W'(signed'({1'b0, wet})) * P1_W'(shaped_s5);
			p2_s6 <= P2_W'(signed'({1'b0, mix_eff})) * P2_W'(dry_s5);
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: align both products to a common scale, add the rounding half
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0] acc_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s7 <= (ACC_W'(p1_s6) <<< SH_WET) + (ACC_W'(p2_s6) <<< SH_DRY) + ROUND_HALF;
		end
	end

	// ------------------------------------------------------------------
	// Output register: floor to the sample fraction and saturate
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]       acc_shr;
	logic signed [ACC_W-1:0]       res_sat;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	assign acc_shr = acc_s7 >>> RSHIFT;

	always_comb begin
		priority if (acc_shr > SAT_MAX) begin
			res_sat = SAT_MAX;
		end else if (acc_shr < SAT_MIN) begin
			res_sat = SAT_MIN;
		end else begin
			res_sat = acc_shr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= v_s7;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_out_q <= res_sat[SAMPLE_BITS-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

`default_nettype wire

FILE: hdl/skwm_checker.sv
// Port-level checker for soft_knee_waveshaper_mix, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module skwm_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [SAMPLE_BITS-1:0] sample_out
);

	// a stalled result stays put until it transfers
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed or dropped");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// the input backs up only behind a result that waits at the output
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the output was free");

endmodule

bind soft_knee_waveshaper_mix skwm_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_skwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for soft_knee_waveshaper_mix: directed vectors, then random samples
// under several register settings and flow-control patterns, checked against a local predictor.
// Depends on skwm_pkg and the soft_knee_waveshaper_mix RTL.

module testbench;

	localparam int SB = 24;
	// x = floor(sample * drive) with the Q1.23 sample and the Q4.12 gain brought to Q.24
	localparam int GAIN_SHIFT = (SB - 1) + 12 - skwm_pkg::IFRAC;
	// the mix sum sits at 24 + 16 fraction bits; round it back to the sample fraction
	localparam int MIX_SHIFT = skwm_pkg::IFRAC + 16 - (SB - 1);
	localparam longint MIX_FULL = 65536;
	localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam skwm_pkg::cfg_idx_t REG_UNUSED = 2'd3;
	localparam int OUT_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	// One directed vector: register setting, sample, and an optional hand-worked result
	typedef struct packed {
		logic [15:0] gain;
		logic [22:0] knee;
		logic [16:0] mix;
		logic poke_spare;
		logic signed [SB-1:0] sample;
		logic hand_checked;
		logic signed [SB-1:0] want;
	} vector_t;

	localparam int NUM_DIRECTED = 24;
	localparam vector_t DIRECTED [NUM_DIRECTED] = '{
		// reset setting: unity drive, a = 0.5, fully wet
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd0, 1'b1, 24'sd0},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd8388607, 1'b0, 24'sd0},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, -24'sd8388608, 1'b1, -24'sd6710886},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd1000, 1'b1, 24'sd1000},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, -24'sd1, 1'b1, -24'sd1},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd4194304, 1'b1, 24'sd4194304},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd4194305, 1'b0, 24'sd0},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, 24'sd6000000, 1'b0, 24'sd0},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, -24'sd6710886, 1'b1, -24'sd6710886},
		'{16'd4096, 23'd4194304, 17'd0, 1'b0, -24'sd6710887, 1'b1, -24'sd6710886},
		// zero drive
		'{16'd0, 23'd4194304, 17'd0, 1'b0, 24'sd8388607, 1'b1, 24'sd0},
		'{16'd0, 23'd4194304, 17'd0, 1'b0, -24'sd8388608, 1'b1, 24'sd0},
		// full drive: top plateau and negative floor
		'{16'd65535, 23'd4194304, 17'd0, 1'b0, 24'sd8388607, 1'b1, 24'sd6291456},
		'{16'd65535, 23'd4194304, 17'd0, 1'b0, -24'sd8388608, 1'b1, -24'sd6710886},
		// threshold just below one: full scale lands on a; the plateau rounds up into saturation
		'{16'd4096, 23'd8388607, 17'd0, 1'b0, 24'sd8388607, 1'b1, 24'sd8388607},
		'{16'd65535, 23'd8388607, 17'd0, 1'b0, 24'sd1000000, 1'b1, 24'sd8388607},
		// threshold zero: the whole positive side is knee
		'{16'd4096, 23'd0, 17'd0, 1'b0, 24'sd4194304, 1'b0, 24'sd0},
		'{16'd4096, 23'd0, 17'd0, 1'b0, 24'sd8388607, 1'b0, 24'sd0},
		// fully dry
		'{16'd4096, 23'd4194304, 17'd65536, 1'b0, 24'sd8388607, 1'b1, 24'sd8388607},
		'{16'd4096, 23'd4194304, 17'd65536, 1'b0, -24'sd8388608, 1'b1, -24'sd8388608},
		// mix above full acts as fully dry
		'{16'd65535, 23'd4194304, 17'd131071, 1'b0, 24'sd12345, 1'b1, 24'sd12345},
		'{16'd65535, 23'd4194304, 17'd131071, 1'b0, -24'sd8388608, 1'b1, -24'sd8388608},
		// half mix, with a write to the unused index that must change nothing
		'{16'd20000, 23'd1234567, 17'd32768, 1'b1, 24'sd5000000, 1'b0, 24'sd0},
		'{16'd20000, 23'd1234567, 17'd32768, 1'b0, -24'sd3000000, 1'b0, 24'sd0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SB-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SB-1:0] sample_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	skwm_pkg::cfg_idx_t cfg_index = skwm_pkg::REG_DRIVE_GAIN;
	skwm_pkg::cfg_data_t cfg_data = '0;

	// local copy of the register file, updated as each write transfers
	logic [15:0] drive_reg = skwm_pkg::DRIVE_GAIN_RST;
	logic [22:0] knee_reg = skwm_pkg::KNEE_THRESHOLD_RST;
	logic [16:0] mix_reg = skwm_pkg::MIX_LEVEL_RST;

	logic signed [SB-1:0] pending_samples [$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int results_checked = 0;
	int samples_sent = 0;
	int settings_applied = 0;
	int input_held = 0;

	soft_knee_waveshaper_mix #(.SAMPLE_BITS(SB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive x through the knee, then blend with the dry sample, round and saturate.
	function automatic logic signed [SB-1:0] shape_and_mix(logic signed [SB-1:0] dry);
		longint dry_l, x, a, shaped, d, span, ratio, ratio_sq, m, acc, res;
		dry_l = dry;
		// arithmetic shift of a signed value floors toward minus infinity
		x = (dry_l * longint'(drive_reg)) >>> GAIN_SHIFT;
		a = longint'(knee_reg) * 2;
		if (x <= a) begin
			shaped = x;
		end else if (x > longint'(skwm_pkg::ONE_Q)) begin
			shaped = (a + longint'(skwm_pkg::ONE_Q)) / 2;
		end else begin
			d = x - a;
			span = longint'(skwm_pkg::ONE_Q) - a;
			ratio = (d << skwm_pkg::IFRAC) / span;
			ratio_sq = (ratio * ratio) >> skwm_pkg::IFRAC;
			shaped = a + (d << skwm_pkg::IFRAC) / (longint'(skwm_pkg::ONE_Q) + ratio_sq);
		end
		// the negative floor wins over every other piece of the curve
		if (x < longint'(skwm_pkg::NEG_LIMIT_Q))
			shaped = longint'(skwm_pkg::NEG_LIMIT_Q);
		m = (longint'(mix_reg) > MIX_FULL) ? MIX_FULL : longint'(mix_reg);
		// the dry sample has one fraction bit less than shaped: scale it up by two
		acc = (MIX_FULL - m) * shaped + m * dry_l * 2;
		res = (acc + (longint'(1) << (MIX_SHIFT - 1))) >>> MIX_SHIFT;
		if (res > SAMPLE_MAX)
			res = SAMPLE_MAX;
		if (res < SAMPLE_MIN)
			res = SAMPLE_MIN;
		return res[SB-1:0];
	endfunction

	// Offer one sample, idling first at the current rate; hold it until it transfers.
	task automatic send_sample(input logic signed [SB-1:0] s, input logic signed [SB-1:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (in_stall) begin
			input_held++;
			@(posedge clk);
		end
		pending_samples = {pending_samples, want};
		samples_sent++;
	endtask

	// Drain the pipeline, then write all three registers (and optionally the unused index).
	task automatic apply_settings(input skwm_pkg::cfg_data_t gain,
			input skwm_pkg::cfg_data_t knee, input skwm_pkg::cfg_data_t mix,
			input logic poke_spare);
		skwm_pkg::cfg_idx_t order [4];
		skwm_pkg::cfg_data_t values [4];
		int count;
		order = '{skwm_pkg::REG_DRIVE_GAIN, skwm_pkg::REG_KNEE_THRESHOLD,
			skwm_pkg::REG_MIX_LEVEL, REG_UNUSED};
		values = '{gain, knee, mix, skwm_pkg::cfg_data_t'($urandom)};
		count = poke_spare ? 4 : 3;
		// drop valid so the held sample is not taken twice, then let every result out
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		for (int i = 0; i < count; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= values[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			// mirror the write with the register's own width
			case (order[i])
				skwm_pkg::REG_DRIVE_GAIN: drive_reg = values[i][15:0];
				skwm_pkg::REG_KNEE_THRESHOLD: knee_reg = values[i][22:0];
				skwm_pkg::REG_MIX_LEVEL: mix_reg = values[i][16:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Result side: check each transfer against the oldest expectation, then pick the
	// next stall. A change of hold_token starts a long hold counted here.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %0d with nothing pending", sample_out);
			end else begin
				if (sample_out !== pending_samples[0]) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected %0d, got %0d", results_checked,
							pending_samples[0], sample_out);
				end
				void'(pending_samples.pop_front());
				results_checked++;
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = OUT_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a correct run finishes far inside this.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic signed [SB-1:0] s;
		skwm_pkg::cfg_data_t gain, knee, mix;
		int wait_cycles;

		// hold reset, then release it once
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed vectors: write registers on a new row setting or a poke of the unused index.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].gain != drive_reg || DIRECTED[i].knee != knee_reg ||
					DIRECTED[i].mix != mix_reg || DIRECTED[i].poke_spare)
				apply_settings(skwm_pkg::cfg_data_t'(DIRECTED[i].gain),
					skwm_pkg::cfg_data_t'(DIRECTED[i].knee),
					skwm_pkg::cfg_data_t'(DIRECTED[i].mix), DIRECTED[i].poke_spare);
			send_sample(DIRECTED[i].sample, DIRECTED[i].hand_checked ?
				DIRECTED[i].want : shape_and_mix(DIRECTED[i].sample));
		end

		// Random phases, cycling through the flow-control patterns: none, sender idle,
		// receiver stalling, both. The last phase holds the output off for a long stretch.
		for (int phase = 0; phase < 9; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct <= 0; stall_pct <= 0; end
				1: begin send_idle_pct <= 78; stall_pct <= 0; end
				2: begin send_idle_pct <= 0; stall_pct <= 78; end
				default: begin send_idle_pct <= 29; stall_pct <= 29; end
			endcase
			// bias register picks toward extremes; random gain and mix picks can carry junk upper bits
			case ($urandom_range(4))
				0: gain = '0;
				1: gain = skwm_pkg::cfg_data_t'(16'hFFFF);
				2: gain = skwm_pkg::cfg_data_t'(skwm_pkg::DRIVE_GAIN_RST);
				default: gain = skwm_pkg::cfg_data_t'($urandom);
			endcase
			case ($urandom_range(3))
				0: knee = '0;
				1: knee = skwm_pkg::cfg_data_t'(23'h7FFFFF);
				default: knee = skwm_pkg::cfg_data_t'($urandom);
			endcase
			case ($urandom_range(4))
				0: mix = '0;
				1: mix = skwm_pkg::cfg_data_t'(MIX_FULL);
				2: mix = skwm_pkg::cfg_data_t'($urandom);
				default: mix = skwm_pkg::cfg_data_t'($urandom_range(65536));
			endcase
			apply_settings(gain, knee, mix, phase == 5);
			if (phase == 8)
				hold_token <= hold_token + 1;
			for (int n = 0; n < ((phase == 8) ? 140 : 95); n++) begin
				case ($urandom_range(7))
					0: s = {1'b0, {(SB-1){1'b1}}};
					1: s = {1'b1, {(SB-1){1'b0}}};
					2: s = SB'(int'($urandom_range(4095)) - 2048);
					default: s = SB'($urandom);
				endcase
				send_sample(s, shape_and_mix(s));
			end
		end

		// Stop offering, wait for the tail, then keep idling to catch strays.
		in_valid <= 1'b0;
		send_idle_pct <= 0;
		stall_pct <= 0;
		wait_cycles = 0;
		while (pending_samples.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_samples.size() != 0) begin
			errors += pending_samples.size();
			$display("%0d expected results never arrived", pending_samples.size());
		end

		$display("Checked %0d results from %0d samples across %0d register settings.",
			results_checked, samples_sent, settings_applied);
		$display("Input was held back for %0d cycles while the output was stalled.",
			input_held);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/skwm_pkg.sv
hdl/skwm_div.sv
hdl/soft_knee_waveshaper_mix.sv
hdl/skwm_checker.sv
test/testbench.sv
